// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the distinct key counter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/hdkc_pkg.sv
// ----------------------------------------------------------------------------
// hdkc_pkg
// Types and constants shared by the distinct key counter modules.
// ----------------------------------------------------------------------------
package hdkc_pkg;

   // Request kinds carried on req_tuser.
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_CLEAR  = 1'b1;

   // Hash constants.
   localparam logic [31:0] HASH_MUL   = 32'd123;
   localparam logic [31:0] HASH_ADD   = 32'd151;
   localparam int          PRIME_W    = 17;
   localparam logic [16:0] HASH_PRIME = 17'h1FFFF;

   // Field widths.
   localparam int KEY_W   = 32;
   localparam int COUNT_W = 16;
   localparam int BIDX_W  = 14;
   localparam int RSP_W   = 32;

   // Controller states.
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH2,
      ST_HASH3,
      ST_HASH4,
      ST_READ,
      ST_UPDATE,
      ST_CLEAR,
      ST_CLR_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic take;
      logic clr_step;
      logic commit;
      logic load_clear;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clr_last;
      logic out_free;
   } sts_type;

endpackage

// File: sv/hashed_distinct_key_counter.sv
// ----------------------------------------------------------------------------
// hashed_distinct_key_counter
// Counts distinct 32-bit addresses in a hash table of BUCKETS rows by WAYS.
// ----------------------------------------------------------------------------
// An insert request is processed in order: the edge that accepts it loads
// the first of four hash pipeline stages, the row of the hashed bucket is
// then read into a register, and the update step compares all ways, writes
// the row back when the address is new and loads the result. The next request
// is accepted the cycle after the result is loaded. A clear request sweeps
// every row through the single table write port, then loads its all-zero
// result, and the next request can be taken the cycle after that. After reset
// the same sweep runs with req_tready low. The result sits in an output
// register, so the next request is accepted while a result still waits; a
// request completes only once that register is free, and it waits in its
// update step while a result held back by rsp_tready is still in the register.
module hashed_distinct_key_counter #(
   parameter int BUCKETS = 10000,
   parameter int WAYS    = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] ip_address
   input  logic        req_tuser,   // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [15:0] distinct_count, [16] was_new,
                                    // [17] bucket_full, [31:18] bucket_index
);

   `include "assert_macros.svh"

   localparam int BKT_W     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOTS     = BUCKETS * WAYS;
   localparam int MAX_COUNT = (SLOTS > 65535) ? 65535 : SLOTS;

   hdkc_pkg::cmd_type cmd;
   hdkc_pkg::sts_type sts;
   logic [BKT_W-1:0]  bucket;

   // Sequencer.
   hdkc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_kind   (req_tuser),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Bucket hash.
   hdkc_hash #(
      .BUCKETS (BUCKETS),
      .BKT_W   (BKT_W)
   ) u_hash (
      .clock   (clock),
      .load    (cmd.take),
      .address (req_tdata),
      .bucket  (bucket)
   );

   // Table, count and result.
   hdkc_dp #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS),
      .BKT_W   (BKT_W)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_address (req_tdata),
      .bucket      (bucket),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata)
   );

   // A result never reports a new address and a full bucket together.
   `ASSERT_IMPLY(a_new_xor_full, clock, reset, rsp_tvalid,
                 !(rsp_tdata[16] && rsp_tdata[17]), "result flags new and full together")

   // The count cannot pass the number of slots.
   `ASSERT_IMPLY(a_count_bound, clock, reset, rsp_tvalid,
                 rsp_tdata[15:0] <= 16'(MAX_COUNT), "distinct count exceeds slot count")

   // The reported bucket lies inside the table.
   `ASSERT_IMPLY(a_bucket_bound, clock, reset, rsp_tvalid,
                 17'(rsp_tdata[31:18]) < 17'(BUCKETS), "bucket index out of range")

   // A clear request yields an all-zero result once its sweep is done.
   `ASSERT_NEXT(a_clear_zero, clock, reset, cmd.load_clear,
                rsp_tvalid && (rsp_tdata == '0), "clear result not zero")

endmodule

// File: sv/hdkc_hash.sv
// ----------------------------------------------------------------------------
// hdkc_hash
// Four-stage bucket hash: (((123*x+151) mod 2^32) mod 131071) mod BUCKETS.
// ----------------------------------------------------------------------------
module hdkc_hash #(
   parameter int BUCKETS = 10000,
   parameter int BKT_W   = 14
) (
   input  logic             clock,
   input  logic             load,
   input  logic [31:0]      address,
   output logic [BKT_W-1:0] bucket
);

   // Reciprocal of the bucket count, scaled by 2^32.
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(BUCKETS));

   logic [31:0]      mul_ff, mul_in;
   logic [16:0]      v1_ff, v1_in;
   logic [16:0]      v2_ff;
   logic [16:0]      q_ff, q_in;
   logic [BKT_W-1:0] bucket_ff, bucket_in;
   logic [17:0]      fold;
   logic [49:0]      prod;
   logic [33:0]      qb;
   logic [17:0]      rem;
   logic [17:0]      rem_fix;

   // Stage one: multiply and add with 32-bit wrap.
   assign mul_in = 32'(address * hdkc_pkg::HASH_MUL) + hdkc_pkg::HASH_ADD;

   // Stage two: reduce modulo 2^17-1 by folding the upper bits onto the lower.
   assign fold  = 18'(mul_ff[31:hdkc_pkg::PRIME_W]) + 18'(mul_ff[hdkc_pkg::PRIME_W-1:0]);
   assign v1_in = (fold >= 18'(hdkc_pkg::HASH_PRIME)) ?
                  17'(fold - 18'(hdkc_pkg::HASH_PRIME)) : 17'(fold);

   // Stage three: quotient estimate by reciprocal multiplication.
   assign prod = 50'(v1_ff) * 50'(RECIP);
   assign q_in = prod[48:32];

   // Stage four: remainder, with one correction for an estimate one low.
   assign qb        = 34'(q_ff) * 34'(BUCKETS);
   assign rem       = 18'(v2_ff) - qb[17:0];
   assign rem_fix   = (rem >= 18'(BUCKETS)) ? rem - 18'(BUCKETS) : rem;
   assign bucket_in = rem_fix[BKT_W-1:0];

   // Pipeline registers; only the first stage waits for a new request.
   always_ff @(posedge clock) begin
      if (load) begin
         mul_ff <= mul_in;
      end
      v1_ff     <= v1_in;
      v2_ff     <= v1_ff;
      q_ff      <= q_in;
      bucket_ff <= bucket_in;
   end

   assign bucket = bucket_ff;

endmodule

// File: sv/hdkc_dp.sv
// ----------------------------------------------------------------------------
// hdkc_dp
// Datapath: bucket table, slot search and update, count and result register.
// ----------------------------------------------------------------------------
module hdkc_dp #(
   parameter int BUCKETS = 10000,
   parameter int WAYS    = 4,
   parameter int BKT_W   = 14
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hdkc_pkg::cmd_type                cmd,
   output hdkc_pkg::sts_type                sts,
   input  logic [hdkc_pkg::KEY_W-1:0]       req_address,
   input  logic [BKT_W-1:0]                 bucket,
   input  logic                             rsp_tready,
   output logic                             rsp_tvalid,
   output logic [hdkc_pkg::RSP_W-1:0]       rsp_tdata
);

   // One row per bucket: valid bits in the low bits, then one key per way.
   localparam int ROW_W = WAYS * (hdkc_pkg::KEY_W + 1);

   logic [ROW_W-1:0]                  mem [BUCKETS];
   logic [ROW_W-1:0]                  rd_row_ff;
   logic [ROW_W-1:0]                  new_row;
   logic [ROW_W-1:0]                  wr_data;
   logic [BKT_W-1:0]                  wr_addr;
   logic                              wr_en;
   logic [hdkc_pkg::KEY_W-1:0]        addr_ff;
   logic [BKT_W-1:0]                  clr_idx_ff, clr_idx_in;
   logic [hdkc_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [hdkc_pkg::RSP_W-1:0]        rsp_data_ff, rsp_data_in;
   logic [WAYS-1:0]                   hit;
   logic                              have_free;
   logic                              found;
   logic                              is_new;
   logic                              is_full;

   // Latch the address of an accepted request.
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         addr_ff <= req_address;
      end
   end

   // Search the bucket row and build the row with the address inserted.
   always_comb begin
      hit       = '0;
      have_free = 1'b0;
      new_row   = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         hit[w] = rd_row_ff[w] &&
                  (rd_row_ff[WAYS + hdkc_pkg::KEY_W*w +: hdkc_pkg::KEY_W] == addr_ff);
         if (!have_free && !rd_row_ff[w]) begin
            have_free  = 1'b1;
            new_row[w] = 1'b1;
            new_row[WAYS + hdkc_pkg::KEY_W*w +: hdkc_pkg::KEY_W] = addr_ff;
         end
      end
   end

   assign found   = |hit;
   assign is_new  = !found && have_free;
   assign is_full = !found && !have_free;

   // Clearing sweep walks every row once and returns to row zero.
   assign sts.clr_last = (clr_idx_ff == BKT_W'(BUCKETS - 1));
   assign clr_idx_in   = sts.clr_last ? '0 : clr_idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_idx_ff <= clr_idx_in;
      end
   end

   // Table port: sweep writes zero rows, an insert writes back its row.
   assign wr_en   = cmd.clr_step || (cmd.commit && is_new);
   assign wr_addr = cmd.clr_step ? clr_idx_ff : bucket;
   assign wr_data = cmd.clr_step ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_row_ff <= mem[bucket];
   end

   // Distinct count, saturating at the top of its range.
   always_comb begin
      count_in = count_ff;
      if (cmd.load_clear) begin
         count_in = '0;
      end else if (cmd.commit && is_new && (count_ff != '1)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register, loaded when it is empty or its waiting result is taken.
   assign sts.out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (cmd.load_clear) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
      end else if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {hdkc_pkg::BIDX_W'(bucket), is_full, is_new, count_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// File: sv/hdkc_ctrl.sv
// ----------------------------------------------------------------------------
// hdkc_ctrl
// Controller: sequences hashing, table read, update and clearing sweeps.
// ----------------------------------------------------------------------------
module hdkc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_kind,
   output logic              req_tready,
   input  hdkc_pkg::sts_type sts,
   output hdkc_pkg::cmd_type cmd
);

   hdkc_pkg::state_type state_ff, state_in;

   // State register; reset starts the table clearing sweep.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hdkc_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         hdkc_pkg::ST_INIT: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = hdkc_pkg::ST_IDLE;
            end
         end
         hdkc_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               state_in = (req_kind == hdkc_pkg::KIND_CLEAR) ?
                          hdkc_pkg::ST_CLEAR : hdkc_pkg::ST_HASH2;
            end
         end
         hdkc_pkg::ST_HASH2: begin
            state_in = hdkc_pkg::ST_HASH3;
         end
         hdkc_pkg::ST_HASH3: begin
            state_in = hdkc_pkg::ST_HASH4;
         end
         hdkc_pkg::ST_HASH4: begin
            state_in = hdkc_pkg::ST_READ;
         end
         hdkc_pkg::ST_READ: begin
            state_in = hdkc_pkg::ST_UPDATE;
         end
         hdkc_pkg::ST_UPDATE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = hdkc_pkg::ST_IDLE;
            end
         end
         hdkc_pkg::ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = hdkc_pkg::ST_CLR_DONE;
            end
         end
         hdkc_pkg::ST_CLR_DONE: begin
            if (sts.out_free) begin
               cmd.load_clear = 1'b1;
               state_in       = hdkc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hdkc_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
